// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a condition at every clock edge outside reset.
`define PN_ASSERT(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("%m: assertion failed");

// Checks that a condition in one cycle is followed by another in the next cycle.
`define PN_ASSERT_NEXT(label, cause, effect) \
  label: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
    else $error("%m: assertion failed");

`endif

// ===== design/pn_pkg.sv =====
`default_nettype none

package pn_pkg;

  localparam int MAX_INPUT_BYTES_DEF = 2048;
  localparam int MAX_SEGMENTS_DEF    = 1024;

  localparam int LIMIT_W    = 12;
  localparam int READ_IDX_W = 11;
  localparam int NORM_LEN_W = 12;

  localparam logic [LIMIT_W-1:0] OUT_LIMIT_RESET = 12'd1024;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam int OUT_FIFO_DEPTH = 3;
  localparam int FIFO_LVL_W     = $clog2(OUT_FIFO_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_IN_LONG  = 3'd2,
    ST_SMALL    = 3'd3,
    ST_OUT_LONG = 3'd4
  } status_t;

  typedef struct packed {
    logic                  op;
    logic [7:0]            path_byte;
    logic                  is_last;
    logic [READ_IDX_W-1:0] read_index;
  } in_word_t;

  typedef struct packed {
    logic [7:0]            out_byte;
    logic [NORM_LEN_W-1:0] norm_length;
    status_t               status;
    logic                  done_res;
  } out_word_t;

endpackage

`default_nettype wire

// ===== design/pn_core.sv =====
`default_nettype none
`include "assert_macros.svh"

module pn_core #(
  parameter int MAX_INPUT_BYTES = pn_pkg::MAX_INPUT_BYTES_DEF,
  parameter int MAX_SEGMENTS    = pn_pkg::MAX_SEGMENTS_DEF
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                take,
  input  pn_pkg::in_word_t                   in_word,
  input  wire logic [pn_pkg::LIMIT_W-1:0]    out_limit,
  output logic                               res_valid,
  output pn_pkg::out_word_t                  res_word
);
  import pn_pkg::*;

  localparam int STORE_DEPTH = MAX_INPUT_BYTES + 1;
  localparam int LEN_W       = $clog2(STORE_DEPTH + 1);
  localparam int CNT_W       = $clog2(MAX_INPUT_BYTES + 1);
  localparam int SEG_W       = $clog2(MAX_SEGMENTS + 1);
  localparam int SA_W        = $clog2(MAX_SEGMENTS);
  localparam int READ_SPAN   = 1 << READ_IDX_W;
  localparam int PATH_DEPTH  = (STORE_DEPTH < READ_SPAN) ? STORE_DEPTH : READ_SPAN;
  localparam int PA_W        = $clog2(PATH_DEPTH);
  localparam int CMP_W       = (LEN_W > LIMIT_W) ? LEN_W : LIMIT_W;
  localparam int IDX_CMP_W   = (LEN_W > READ_IDX_W) ? LEN_W : READ_IDX_W;
  localparam logic IDX_ALL_IN = (STORE_DEPTH >= READ_SPAN);

  typedef enum logic [1:0] {
    SEL_ZERO,
    SEL_SLASH,
    SEL_MEM
  } byte_sel_t;

  logic [7:0]       path_mem [PATH_DEPTH];
  logic [LEN_W-1:0] seg_mem  [MAX_SEGMENTS];

  logic [SEG_W-1:0] seg_cnt, seg_cnt_next;
  logic [LEN_W-1:0] slen, slen_next;
  logic [CNT_W-1:0] icnt, icnt_next;
  logic [LEN_W-1:0] olen, olen_next;
  logic             dots, dots_next;
  logic             err, err_next;
  logic             nul, nul_next;
  logic             pdone, pdone_next;
  logic [LEN_W-1:0] top, top_next;
  logic [LEN_W-1:0] sec, sec_next;
  logic             top_pend, top_pend_next;
  logic             sec_pend, sec_pend_next;
  logic [LEN_W-1:0] rd_top;
  logic [LEN_W-1:0] rd_sec;

  logic             path_we;
  logic [LEN_W-1:0] path_wa;
  logic [7:0]       path_wd;
  logic             seg_we;
  logic [SA_W-1:0]  seg_wa;
  logic [LEN_W-1:0] seg_wd;
  logic             stack_rd;
  logic [SA_W-1:0]  rd_top_addr;
  logic [SA_W-1:0]  rd_sec_addr;
  logic             path_re;

  byte_sel_t        sel, sel_next;
  logic [7:0]       path_rd;
  logic [NORM_LEN_W-1:0] len_q, len_next;
  status_t          status_q, status_next;
  logic             done_q, done_next;

  always_comb begin : step
    logic [LEN_W-1:0] k0;
    logic [LEN_W-1:0] k1;
    logic [1:0]       pops;
    logic             close_now;
    logic             slash_taken;
    logic [LEN_W-1:0] len_fin;
    logic             idx_in;
    logic [7:0]       b;

    b           = in_word.path_byte;
    k0          = top_pend ? rd_top : top;
    k1          = sec_pend ? rd_sec : sec;
    pops        = 2'd0;
    close_now   = 1'b0;
    slash_taken = 1'b0;
    len_fin     = '0;

    seg_cnt_next  = seg_cnt;
    slen_next     = slen;
    icnt_next     = icnt;
    olen_next     = olen;
    dots_next     = dots;
    err_next      = err;
    nul_next      = nul;
    pdone_next    = pdone;
    top_next      = top;
    sec_next      = sec;
    top_pend_next = top_pend;
    sec_pend_next = sec_pend;

    path_we     = 1'b0;
    path_wa     = slen;
    path_wd     = CH_SLASH;
    seg_we      = 1'b0;
    seg_wa      = seg_cnt[SA_W-1:0];
    seg_wd      = slen;
    stack_rd    = 1'b0;
    rd_top_addr = '0;
    rd_sec_addr = '0;
    path_re     = 1'b0;

    sel_next    = SEL_ZERO;
    status_next = ST_OK;
    done_next   = 1'b0;

    idx_in = IDX_ALL_IN ? 1'b1 : (in_word.read_index < READ_IDX_W'(STORE_DEPTH));

    if (in_word.op == OP_READ) begin
      if (in_word.read_index == '0) begin
        sel_next = SEL_SLASH;
      end else if (slen != '0 && idx_in &&
                   IDX_CMP_W'(in_word.read_index) < IDX_CMP_W'(slen)) begin
        sel_next = SEL_MEM;
        path_re  = 1'b1;
      end
    end else begin
      if (pdone) begin
        seg_cnt_next = '0;
        slen_next    = '0;
        icnt_next    = '0;
        olen_next    = '0;
        dots_next    = 1'b1;
        err_next     = 1'b0;
        nul_next     = 1'b0;
        pdone_next   = 1'b0;
      end

      if (!nul_next && !err_next) begin
        if (b == CH_NUL) begin
          nul_next = 1'b1;
        end else if (icnt_next >= CNT_W'(MAX_INPUT_BYTES)) begin
          err_next = 1'b1;
        end else if (b == CH_SLASH) begin
          icnt_next   = icnt_next + CNT_W'(1);
          close_now   = 1'b1;
          slash_taken = 1'b1;
        end else if (olen_next == '0 && (seg_cnt_next >= SEG_W'(MAX_SEGMENTS) ||
                                         slen_next > LEN_W'(STORE_DEPTH - 2))) begin
          err_next = 1'b1;
        end else if (olen_next != '0 && slen_next >= LEN_W'(STORE_DEPTH)) begin
          err_next = 1'b1;
        end else begin
          if (olen_next == '0) begin
            seg_we       = 1'b1;
            seg_wa       = seg_cnt_next[SA_W-1:0];
            seg_wd       = slen_next;
            k1           = k0;
            k0           = slen_next;
            seg_cnt_next = seg_cnt_next + SEG_W'(1);
            slen_next    = slen_next + LEN_W'(1);
            dots_next    = 1'b1;
          end
          icnt_next = icnt_next + CNT_W'(1);
          path_we   = 1'b1;
          path_wa   = slen_next;
          path_wd   = b;
          slen_next = slen_next + LEN_W'(1);
          olen_next = olen_next + LEN_W'(1);
          if (b != CH_DOT) begin
            dots_next = 1'b0;
          end
        end
      end

      if (in_word.is_last) begin
        done_next  = 1'b1;
        pdone_next = 1'b1;
        if (!err_next) begin
          close_now = 1'b1;
        end
      end

      if (close_now && olen_next != '0) begin
        if (dots_next && olen_next == LEN_W'(1)) begin
          pops = 2'd1;
        end else if (dots_next && olen_next == LEN_W'(2)) begin
          pops = 2'd2;
        end
        olen_next = '0;
        dots_next = 1'b1;
      end

      if (seg_cnt_next == '0) begin
        pops = 2'd0;
      end else if (pops == 2'd2 && seg_cnt_next == SEG_W'(1)) begin
        pops = 2'd1;
      end

      case (pops)
        2'd1: begin
          slen_next     = k0;
          seg_cnt_next  = seg_cnt_next - SEG_W'(1);
          top_next      = k1;
          top_pend_next = 1'b0;
          sec_pend_next = 1'b1;
          stack_rd      = 1'b1;
        end
        2'd2: begin
          slen_next     = k1;
          seg_cnt_next  = seg_cnt_next - SEG_W'(2);
          top_pend_next = 1'b1;
          sec_pend_next = 1'b1;
          stack_rd      = 1'b1;
        end
        default: begin
          top_next      = k0;
          sec_next      = k1;
          top_pend_next = 1'b0;
          sec_pend_next = 1'b0;
        end
      endcase
      rd_top_addr = SA_W'(seg_cnt_next - SEG_W'(1));
      rd_sec_addr = SA_W'(seg_cnt_next - SEG_W'(2));

      if (slash_taken) begin
        path_we = 1'b1;
        path_wa = slen_next;
        path_wd = CH_SLASH;
      end

      if (done_next) begin
        len_fin = (slen_next == '0) ? LEN_W'(1) : slen_next;
        if (icnt_next == '0 && !err_next) begin
          status_next = ST_EMPTY;
        end else if (err_next) begin
          status_next = ST_IN_LONG;
        end else if (out_limit < LIMIT_W'(2)) begin
          status_next = ST_SMALL;
        end else if (CMP_W'(len_fin) >= CMP_W'(out_limit)) begin
          status_next = ST_OUT_LONG;
        end
      end
    end

    len_next = (slen_next == '0) ? NORM_LEN_W'(1) : NORM_LEN_W'(slen_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_cnt   <= '0;
      slen      <= '0;
      icnt      <= '0;
      olen      <= '0;
      dots      <= 1'b1;
      err       <= 1'b0;
      nul       <= 1'b0;
      pdone     <= 1'b0;
      top_pend  <= 1'b0;
      sec_pend  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      res_valid <= take;
      if (take) begin
        seg_cnt  <= seg_cnt_next;
        slen     <= slen_next;
        icnt     <= icnt_next;
        olen     <= olen_next;
        dots     <= dots_next;
        err      <= err_next;
        nul      <= nul_next;
        pdone    <= pdone_next;
        top_pend <= top_pend_next;
        sec_pend <= sec_pend_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      top      <= top_next;
      sec      <= sec_next;
      sel      <= sel_next;
      len_q    <= len_next;
      status_q <= status_next;
      done_q   <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take && path_we && path_wa < LEN_W'(PATH_DEPTH)) begin
      path_mem[PA_W'(path_wa)] <= path_wd;
    end
    if (take && path_re) begin
      path_rd <= path_mem[in_word.read_index[PA_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (take && seg_we) begin
      seg_mem[seg_wa] <= seg_wd;
    end
    if (take && stack_rd) begin
      rd_top <= seg_mem[rd_top_addr];
      rd_sec <= seg_mem[rd_sec_addr];
    end
  end

  always_comb begin
    unique case (sel)
      SEL_SLASH: res_word.out_byte = CH_SLASH;
      SEL_MEM:   res_word.out_byte = path_rd;
      default:   res_word.out_byte = 8'h00;
    endcase
    res_word.norm_length = len_q;
    res_word.status      = status_q;
    res_word.done_res    = done_q;
  end

  `PN_ASSERT(a_len_bound, slen <= LEN_W'(STORE_DEPTH))
  `PN_ASSERT(a_open_in_store, olen <= slen)
  `PN_ASSERT(a_status_only_done, !res_valid || res_word.done_res || res_word.status == ST_OK)
  `PN_ASSERT_NEXT(a_read_keeps_state, take && in_word.op == OP_READ, $stable(slen) && $stable(seg_cnt))

endmodule

`default_nettype wire

// ===== design/pn_out_fifo.sv =====
`default_nettype none
`include "assert_macros.svh"

module pn_out_fifo (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   push,
  input  pn_pkg::out_word_t                     push_word,
  output logic [pn_pkg::FIFO_LVL_W-1:0]         level,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output pn_pkg::out_word_t                     out_word
);
  import pn_pkg::*;

  localparam int PTR_W = $clog2(OUT_FIFO_DEPTH);

  out_word_t             slots [OUT_FIFO_DEPTH];
  logic [PTR_W-1:0]      wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0]      rd_ptr, rd_ptr_next;
  logic [FIFO_LVL_W-1:0] cnt, cnt_next;
  logic                  pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt != '0);
  assign out_word  = slots[rd_ptr];
  assign level     = cnt;

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    if (push) begin
      wr_ptr_next = (wr_ptr == PTR_W'(OUT_FIFO_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_next = (rd_ptr == PTR_W'(OUT_FIFO_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
    end
    cnt_next = cnt + FIFO_LVL_W'(push) - FIFO_LVL_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      cnt    <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_word;
    end
  end

  `PN_ASSERT(a_no_overflow, !(push && !pop && cnt == FIFO_LVL_W'(OUT_FIFO_DEPTH)))
  `PN_ASSERT_NEXT(a_fill_tracks, push && !pop, cnt == $past(cnt) + FIFO_LVL_W'(1))
  `PN_ASSERT_NEXT(a_drain_tracks, pop && !push, cnt == $past(cnt) - FIFO_LVL_W'(1))

endmodule

`default_nettype wire

// ===== design/path_normalizer.sv =====
// Path normalizer: builds the normalized form of an absolute path one byte at a time.
// Input channel (in_valid, in_ready, in_word): op selects a push of path_byte, with
// is_last marking the final byte of a path, or a read of the stored normalized byte at
// read_index. The first push after a finished path starts a new one.
// Output channel (out_valid, out_ready, out_word): exactly one word per input word, in
// order. A push returns the current normalized length, and on its last byte the status
// and done_res. A read returns the byte with the current length.
// Configuration: cfg_we writes cfg_data into the output limit; write only when idle.
// A word passes the result register, then the output queue, to out_valid; one word is
// accepted every cycle while in_ready is high. All state updates for a word happen at its
// acceptance edge against the path and segment-start memories; a dot-dot segment refills
// the cached stack top from the segment memory with a registered read in the same edge.
// A three-entry output queue stands after the result register; in_ready drops only
// when that queue and the result register together hold three words, so a stalled
// receiver holds back at most three results and no word is lost.
// A synchronous reset empties the queue, clears the path state to an empty path and
// sets the output limit to 1024. The memories need no clearing.

`default_nettype none

module path_normalizer #(
  parameter int MAX_INPUT_BYTES = pn_pkg::MAX_INPUT_BYTES_DEF,
  parameter int MAX_SEGMENTS    = pn_pkg::MAX_SEGMENTS_DEF
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             in_valid,
  output logic                            in_ready,
  input  pn_pkg::in_word_t                in_word,
  output logic                            out_valid,
  input  wire                             out_ready,
  output pn_pkg::out_word_t               out_word,
  input  wire                             cfg_we,
  input  wire logic [pn_pkg::LIMIT_W-1:0] cfg_data
);
  import pn_pkg::*;

  logic [LIMIT_W-1:0]    out_limit;
  logic                  take;
  logic                  res_valid;
  out_word_t             res_word;
  logic [FIFO_LVL_W-1:0] level;
  logic [FIFO_LVL_W:0]   held;

  assign held     = {1'b0, level} + (FIFO_LVL_W + 1)'(res_valid);
  assign in_ready = (held < (FIFO_LVL_W + 1)'(OUT_FIFO_DEPTH));
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_limit <= OUT_LIMIT_RESET;
    end else if (cfg_we) begin
      out_limit <= cfg_data;
    end
  end

  pn_core #(
    .MAX_INPUT_BYTES (MAX_INPUT_BYTES),
    .MAX_SEGMENTS    (MAX_SEGMENTS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .in_word   (in_word),
    .out_limit (out_limit),
    .res_valid (res_valid),
    .res_word  (res_word)
  );

  pn_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_word (res_word),
    .level     (level),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire

// ===== test/path_norm_checker.sv =====
module path_norm_checker
  import pn_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  in_word_t             in_word,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  out_word_t            out_word,
  input  logic                 cfg_we,
  input  logic [LIMIT_W-1:0]   cfg_data,
  output int                   fail_count,
  output int                   pending_words
);

  localparam int MAX_IN      = MAX_INPUT_BYTES_DEF;
  localparam int MAX_SEG     = MAX_SEGMENTS_DEF;
  localparam int STORE_DEPTH = MAX_IN + 1;

  logic [7:0]  path_mem [0:STORE_DEPTH-1];
  int unsigned seg_starts [0:MAX_SEG-1];
  int unsigned seg_count;
  int unsigned stored_len;
  int unsigned in_count;
  int unsigned open_len;
  int unsigned limit_reg;
  bit          all_dots;
  bit          nul_seen;
  bit          path_done;
  status_t     sticky;

  out_word_t   expected_words [$];

  function automatic void start_path();
    seg_count  = 0;
    stored_len = 0;
    in_count   = 0;
    open_len   = 0;
    all_dots   = 1'b1;
    sticky     = ST_OK;
    nul_seen   = 1'b0;
    path_done  = 1'b0;
  endfunction

  function automatic void pop_segment();
    if (seg_count != 0) begin
      seg_count  = seg_count - 1;
      stored_len = seg_starts[seg_count];
    end
  endfunction

  // A component made only of dots is "." when one long and ".." when two long.
  function automatic void close_segment();
    if (open_len == 0) return;
    if (all_dots && open_len == 1) begin
      pop_segment();
    end else if (all_dots && open_len == 2) begin
      pop_segment();
      pop_segment();
    end
    open_len = 0;
    all_dots = 1'b1;
  endfunction

  function automatic void take_byte(logic [7:0] b);
    if (in_count >= MAX_IN) begin
      sticky = ST_IN_LONG;
      return;
    end
    if (b == CH_SLASH) begin
      in_count = in_count + 1;
      close_segment();
      return;
    end
    if (open_len == 0) begin
      if (seg_count >= MAX_SEG || stored_len + 2 > STORE_DEPTH) begin
        sticky = ST_IN_LONG;
        return;
      end
      seg_starts[seg_count] = stored_len;
      seg_count = seg_count + 1;
      path_mem[stored_len] = CH_SLASH;
      stored_len = stored_len + 1;
      all_dots = 1'b1;
    end else if (stored_len + 1 > STORE_DEPTH) begin
      sticky = ST_IN_LONG;
      return;
    end
    in_count = in_count + 1;
    path_mem[stored_len] = b;
    stored_len = stored_len + 1;
    open_len = open_len + 1;
    if (b != CH_DOT) all_dots = 1'b0;
  endfunction

  function automatic out_word_t normalize_word(in_word_t w);
    out_word_t   r;
    int unsigned len;
    r = '0;
    if (w.op == OP_READ) begin
      if (stored_len == 0) begin
        r.out_byte = (w.read_index == 0) ? CH_SLASH : CH_NUL;
      end else if (w.read_index < stored_len) begin
        r.out_byte = path_mem[w.read_index];
      end
    end else begin
      if (path_done) start_path();
      if (!nul_seen && sticky != ST_IN_LONG) begin
        if (w.path_byte == CH_NUL) nul_seen = 1'b1;
        else take_byte(w.path_byte);
      end
      if (w.is_last) begin
        if (sticky != ST_IN_LONG) close_segment();
        len = (stored_len == 0) ? 1 : stored_len;
        if (in_count == 0 && sticky != ST_IN_LONG) r.status = ST_EMPTY;
        else if (sticky == ST_IN_LONG) r.status = ST_IN_LONG;
        else if (limit_reg < 2) r.status = ST_SMALL;
        else if (len >= limit_reg) r.status = ST_OUT_LONG;
        else r.status = ST_OK;
        r.done_res = 1'b1;
        path_done = 1'b1;
      end
    end
    len = (stored_len == 0) ? 1 : stored_len;
    r.norm_length = len[NORM_LEN_W-1:0];
    return r;
  endfunction

  initial begin
    fail_count    = 0;
    pending_words = 0;
  end

  always @(posedge clk) begin
    out_word_t exp_word;
    if (rst) begin
      start_path();
      limit_reg = OUT_LIMIT_RESET;
      expected_words.delete();
    end else begin
      if (cfg_we) limit_reg = cfg_data;
      if (in_valid && in_ready) expected_words.push_back(normalize_word(in_word));
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected word: byte %0h len %0d status %0d done %0b",
                     out_word.out_byte, out_word.norm_length, out_word.status,
                     out_word.done_res);
          fail_count = fail_count + 1;
        end else begin
          exp_word = expected_words.pop_front();
          if (out_word.out_byte !== exp_word.out_byte ||
              out_word.norm_length !== exp_word.norm_length ||
              out_word.status !== exp_word.status ||
              out_word.done_res !== exp_word.done_res) begin
            if (fail_count < 10)
              $display("mismatch: expected byte %0h len %0d status %0d done %0b, %s",
                       exp_word.out_byte, exp_word.norm_length, exp_word.status,
                       exp_word.done_res,
                       $sformatf("got byte %0h len %0d status %0d done %0b",
                                 out_word.out_byte, out_word.norm_length,
                                 out_word.status, out_word.done_res));
            fail_count = fail_count + 1;
          end
        end
      end
    end
    pending_words = expected_words.size();
  end

endmodule

// ===== test/tb.sv =====
module tb;
  import pn_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  in_word_t           in_word;
  logic               out_valid;
  logic               out_ready;
  out_word_t          out_word;
  logic               cfg_we;
  logic [LIMIT_W-1:0] cfg_data;

  int fail_count;
  int pending_words;
  int idle_pct;
  int stall_pct;
  int words_sent;
  int quiet_cycles;
  bit hold_req;

  path_normalizer u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  path_norm_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_word       (in_word),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_word      (out_word),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_words (pending_words)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The receiver stalls at random, and once on request holds off for a long stretch.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [READ_IDX_W-1:0] rand_index();
    if ($urandom_range(7) == 0) return READ_IDX_W'($urandom_range(2047));
    return READ_IDX_W'($urandom_range(24));
  endfunction

  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_word  = w;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic push_byte(input logic [7:0] b, input logic last);
    in_word_t w;
    w.op         = OP_PUSH;
    w.path_byte  = b;
    w.is_last    = last;
    w.read_index = READ_IDX_W'($urandom_range(2047));
    send_word(w);
  endtask

  task automatic read_at(input logic [READ_IDX_W-1:0] idx);
    in_word_t w;
    w.op         = OP_READ;
    w.path_byte  = 8'($urandom_range(255));
    w.is_last    = 1'($urandom_range(1));
    w.read_index = idx;
    send_word(w);
  endtask

  task automatic push_string(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], i == s.len() - 1);
  endtask

  task automatic send_path();
    logic [7:0] path_bytes [$];
    logic [7:0] b;
    int         n_comp;
    int         kind;
    int         n;
    if ($urandom_range(15) == 0) begin
      path_bytes.push_back(CH_NUL);
    end else begin
      n_comp = $urandom_range(5);
      for (int i = 0; i < n_comp; i++) begin
        if (i > 0 || $urandom_range(7) != 0) begin
          n = ($urandom_range(3) == 0) ? $urandom_range(2, 3) : 1;
          repeat (n) path_bytes.push_back(CH_SLASH);
        end
        kind = $urandom_range(5);
        if (kind < 3) begin
          repeat (kind + 1) path_bytes.push_back(CH_DOT);
        end else begin
          repeat ($urandom_range(1, 6)) begin
            b = ($urandom_range(3) == 0) ? 8'($urandom_range(1, 255)) :
                                           8'("a" + $urandom_range(25));
            if (b == CH_SLASH) b = "z";
            path_bytes.push_back(b);
          end
        end
      end
      if ($urandom_range(3) == 0) path_bytes.push_back(CH_SLASH);
      if (path_bytes.size() == 0) path_bytes.push_back(CH_SLASH);
      if ($urandom_range(11) == 0) path_bytes[$urandom_range(path_bytes.size() - 1)] = CH_NUL;
    end
    for (int i = 0; i < path_bytes.size(); i++) begin
      if ($urandom_range(5) == 0) read_at(rand_index());
      push_byte(path_bytes[i], i == path_bytes.size() - 1);
    end
    repeat ($urandom_range(2)) read_at(rand_index());
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] v);
    while (pending_words != 0) @(negedge clk);
    cfg_data = v;
    cfg_we   = 1'b1;
    @(negedge clk);
    cfg_we   = 1'b0;
  endtask

  task automatic run_phase(input logic [LIMIT_W-1:0] limit, input int s_idle,
                           input int r_stall, input int n_words, input bit with_hold);
    write_limit(limit);
    idle_pct   = s_idle;
    stall_pct  = r_stall;
    hold_req   = with_hold;
    words_sent = 0;
    while (words_sent < n_words) send_path();
    in_valid = 1'b0;
  endtask

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    in_word      = '0;
    cfg_we       = 1'b0;
    cfg_data     = '0;
    idle_pct     = 0;
    stall_pct    = 0;
    hold_req     = 1'b0;
    words_sent   = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed words on the reset limit.
    read_at(0);
    read_at(3);
    push_string("/");
    push_byte(CH_NUL, 1'b1);
    push_string("//a/./b/..");
    read_at(1);
    read_at(2);
    read_at(2047);
    push_string("/../.");
    push_string("x/..");
    push_byte(CH_SLASH, 1'b0);
    push_byte("a", 1'b0);
    read_at(1);
    push_byte(CH_NUL, 1'b0);
    push_byte("b", 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h80, 1'b1);
    in_valid = 1'b0;

    // A deep path on a limit below two, then every component dropped again.
    write_limit(12'd1);
    for (int i = 0; i < 20; i++) begin
      push_byte(CH_SLASH, 1'b0);
      push_byte(8'("a" + (i % 26)), 1'b0);
    end
    read_at(39);
    for (int i = 0; i < 20; i++) begin
      push_byte(CH_SLASH, 1'b0);
      push_byte(CH_DOT, 1'b0);
      push_byte(CH_DOT, i == 19);
    end
    read_at(2047);
    read_at(1);
    read_at(0);
    in_valid = 1'b0;

    run_phase(12'd4095, 0, 0, 200, 1'b1);
    run_phase(12'd0, 76, 0, 150, 1'b0);
    run_phase(12'd1, 0, 76, 150, 1'b0);
    run_phase(12'd2, 16, 16, 150, 1'b0);
    run_phase(LIMIT_W'($urandom_range(3, 40)), 0, 0, 150, 1'b0);
    run_phase(12'd2048, 76, 0, 150, 1'b0);
    run_phase(LIMIT_W'($urandom_range(3, 40)), 0, 76, 150, 1'b0);
    run_phase(12'd1024, 16, 16, 150, 1'b0);

    while (pending_words != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0 && pending_words == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
